// ===== hw/rtl/pip_pkg.sv =====
// shared types and constants for the point-in-polygon tester
// no dependencies; imported by pip_ctrl, pip_datapath and the top level
package pip_pkg;

    // defaults for the top-level parameters
    localparam int DEF_MAX_VERTICES = 64;
    localparam int DEF_COORD_WIDTH  = 16;

    // fixed field widths
    localparam int INDEX_WIDTH = 6;
    localparam int COUNT_WIDTH = 7;
    localparam int PADDR_WIDTH = 3;
    localparam int PDATA_WIDTH = 32;

    // item modes
    localparam logic MODE_LOAD = 1'b0;
    localparam logic MODE_TEST = 1'b1;

    // register word index, taken from paddr[2]
    localparam logic REG_VERTEX_COUNT = 1'b0;

    // commands from the controller to the datapath
    typedef struct packed {
        logic load;      // write one vertex into the table
        logic start;     // latch the test point, clear hit and parity
        logic rd_en;     // read one vertex for the edge walk
        logic rd_first;  // the read vertex is vertex 0 (no edge ends there)
        logic out_load;  // move the verdict into the output register
    } cmd_t;

    // status from the datapath to the controller
    typedef struct packed {
        logic out_free;  // output register can take a result this cycle
    } status_t;

endpackage

// ===== hw/rtl/pip_ctrl.sv =====
// controller state machine for the point-in-polygon tester
// depends on pip_pkg; drives commands and read addresses into pip_datapath
module pip_ctrl
    import pip_pkg::*;
#(
    parameter int MAX_VERTICES = DEF_MAX_VERTICES,
    localparam int ADDR_WIDTH = $clog2(MAX_VERTICES)
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic                   mode,
    input  logic [INDEX_WIDTH-1:0] vertex_index,
    input  logic [COUNT_WIDTH-1:0] vertex_count,
    input  status_t                status,
    output cmd_t                   cmd,
    output logic [ADDR_WIDTH-1:0]  wr_addr,
    output logic [ADDR_WIDTH-1:0]  rd_addr
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_WALK   = 2'd1;
    localparam logic [1:0] ST_DRAIN  = 2'd2;
    localparam logic [1:0] ST_FINISH = 2'd3;

    // last drain step, as the last edge passes the read, difference and product stages
    localparam logic [1:0] DRAIN_LAST = 2'd2;

    logic [1:0]             state_reg, state_next;
    logic [ADDR_WIDTH-1:0]  k_reg, k_next;
    logic [COUNT_WIDTH-1:0] n_reg, n_next;
    logic [1:0]             drain_reg, drain_next;
    logic                   accept;
    logic [COUNT_WIDTH-1:0] n_eff;
    logic                   k_last;

    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;
    assign wr_addr  = ADDR_WIDTH'(vertex_index);
    assign rd_addr  = k_reg;

    // vertex count saturates at the table depth
    assign n_eff  = (32'(vertex_count) > MAX_VERTICES) ? COUNT_WIDTH'(MAX_VERTICES)
                                                       : vertex_count;
    assign k_last = ((32'(k_reg) + 32'd1) == 32'(n_reg));

    // next state and commands
    always_comb
    begin
        state_next   = state_reg;
        k_next       = k_reg;
        n_next       = n_reg;
        drain_next   = drain_reg;
        cmd          = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && (mode == MODE_LOAD))
                begin
                    cmd.load = (32'(vertex_index) < MAX_VERTICES);
                end
                if (accept && (mode == MODE_TEST))
                begin
                    cmd.start = 1'b1;
                    k_next    = '0;
                    n_next    = n_eff;
                    if (n_eff < COUNT_WIDTH'(2))
                    begin
                        state_next = ST_FINISH;
                    end
                    else
                    begin
                        state_next = ST_WALK;
                    end
                end
            end
            ST_WALK:
            begin
                cmd.rd_en    = 1'b1;
                cmd.rd_first = (k_reg == '0);
                if (k_last)
                begin
                    drain_next = '0;
                    state_next = ST_DRAIN;
                end
                else
                begin
                    k_next = k_reg + ADDR_WIDTH'(1);
                end
            end
            ST_DRAIN:
            begin
                drain_next = drain_reg + 2'd1;
                if (drain_reg == DRAIN_LAST)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            k_reg     <= '0;
            n_reg     <= '0;
            drain_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            k_reg     <= k_next;
            n_reg     <= n_next;
            drain_reg <= drain_next;
        end
    end

`ifndef SYNTHESIS
    // a test item blocks further items on the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (mode == MODE_TEST)) |=> !in_ready)
        else $error("test item did not leave idle");

    // a verdict is only moved into a free output register
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> status.out_free)
        else $error("output register overwritten");

    // every edge walk starts at vertex 0
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(cmd.rd_en) |-> cmd.rd_first)
        else $error("edge walk did not start at vertex 0");

    // no table write while a walk is running
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.rd_en |-> !cmd.load)
        else $error("table write during edge walk");
`endif

endmodule

// ===== hw/rtl/pip_datapath.sv =====
// vertex table, edge pipeline and output register of the point-in-polygon tester
// depends on pip_pkg; commanded by pip_ctrl
module pip_datapath
    import pip_pkg::*;
#(
    parameter int MAX_VERTICES = DEF_MAX_VERTICES,
    parameter int COORD_WIDTH  = DEF_COORD_WIDTH,
    localparam int ADDR_WIDTH = $clog2(MAX_VERTICES)
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  cmd_t                          cmd,
    input  logic [ADDR_WIDTH-1:0]         wr_addr,
    input  logic [ADDR_WIDTH-1:0]         rd_addr,
    input  logic signed [COORD_WIDTH-1:0] coord_x,
    input  logic signed [COORD_WIDTH-1:0] coord_y,
    input  logic                          out_ready,
    output status_t                       status,
    output logic                          out_valid,
    output logic                          inside_res
);

    localparam int DW = COORD_WIDTH + 1;
    localparam int PW = 2 * DW;
    localparam int CW = PW + 1;

    // vertex table
    logic signed [COORD_WIDTH-1:0] vtx_x_reg [MAX_VERTICES];
    logic signed [COORD_WIDTH-1:0] vtx_y_reg [MAX_VERTICES];

    // test point
    logic signed [COORD_WIDTH-1:0] px_reg, py_reg;

    // read stage: vertex b of the current edge
    logic                          m_valid_reg, m_first_reg;
    logic signed [COORD_WIDTH-1:0] xb_reg, yb_reg;
    // previous vertex: vertex a of the current edge
    logic signed [COORD_WIDTH-1:0] xa_reg, ya_reg;

    // difference stage
    logic                 a_valid_reg;
    logic signed [DW-1:0] dxp_reg, dya_reg, dxa_reg, dyp_reg;
    logic                 a_eq_reg, a_strad_reg, a_ylt_reg;
    logic signed [DW-1:0] dxp_next, dya_next, dxa_next, dyp_next;
    logic                 eq_next, strad_next, ylt_next;

    // product stage
    logic                 p_valid_reg;
    logic signed [PW-1:0] p1_reg, p2_reg;
    logic                 p_eq_reg, p_strad_reg, p_ylt_reg;

    // verdict and output
    logic                 hit_reg, hit_next;
    logic                 parity_reg, parity_next;
    logic signed [CW-1:0] cross_val;
    logic                 cross_zero, cross_neg;
    logic                 out_valid_reg, out_valid_next;
    logic                 inside_res_reg;

    // table write and registered read
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            vtx_x_reg[wr_addr] <= coord_x;
            vtx_y_reg[wr_addr] <= coord_y;
        end
        if (cmd.rd_en)
        begin
            xb_reg <= vtx_x_reg[rd_addr];
            yb_reg <= vtx_y_reg[rd_addr];
        end
    end

    // edge terms from vertex a, vertex b and the point
    assign dxp_next   = DW'(px_reg) - DW'(xb_reg);
    assign dya_next   = DW'(ya_reg) - DW'(yb_reg);
    assign dxa_next   = DW'(xa_reg) - DW'(xb_reg);
    assign dyp_next   = DW'(py_reg) - DW'(yb_reg);
    assign eq_next    = (px_reg == xb_reg) && (py_reg == yb_reg);
    assign strad_next = (yb_reg > py_reg) != (ya_reg > py_reg);
    assign ylt_next   = (ya_reg < yb_reg);

    // cross product sign and the parity update
    assign cross_val  = CW'(p1_reg) - CW'(p2_reg);
    assign cross_zero = (cross_val == '0);
    assign cross_neg  = cross_val[CW-1];

    always_comb
    begin
        hit_next    = hit_reg;
        parity_next = parity_reg;
        if (cmd.start)
        begin
            hit_next    = 1'b0;
            parity_next = 1'b0;
        end
        else if (p_valid_reg)
        begin
            if (p_eq_reg || (p_strad_reg && cross_zero))
            begin
                hit_next = 1'b1;
            end
            else if (p_strad_reg && (cross_neg != p_ylt_reg))
            begin
                parity_next = !parity_reg;
            end
        end
    end

    // output register handshake
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // pipeline payload
    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            px_reg <= coord_x;
            py_reg <= coord_y;
        end
        if (m_valid_reg)
        begin
            xa_reg <= xb_reg;
            ya_reg <= yb_reg;
        end
        dxp_reg     <= dxp_next;
        dya_reg     <= dya_next;
        dxa_reg     <= dxa_next;
        dyp_reg     <= dyp_next;
        a_eq_reg    <= eq_next;
        a_strad_reg <= strad_next;
        a_ylt_reg   <= ylt_next;
        p1_reg      <= PW'(dxp_reg) * PW'(dya_reg);
        p2_reg      <= PW'(dxa_reg) * PW'(dyp_reg);
        p_eq_reg    <= a_eq_reg;
        p_strad_reg <= a_strad_reg;
        p_ylt_reg   <= a_ylt_reg;
        if (cmd.out_load)
        begin
            inside_res_reg <= hit_reg || parity_reg;
        end
    end

    // pipeline control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg   <= 1'b0;
            m_first_reg   <= 1'b0;
            a_valid_reg   <= 1'b0;
            p_valid_reg   <= 1'b0;
            hit_reg       <= 1'b0;
            parity_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            m_valid_reg   <= cmd.rd_en;
            m_first_reg   <= cmd.rd_first;
            a_valid_reg   <= m_valid_reg && !m_first_reg;
            p_valid_reg   <= a_valid_reg;
            hit_reg       <= hit_next;
            parity_reg    <= parity_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign status.out_free = !out_valid_reg || out_ready;
    assign out_valid       = out_valid_reg;
    assign inside_res      = inside_res_reg;

endmodule

// ===== hw/rtl/point_in_polygon_test.sv =====
// Point-in-polygon tester, even-odd crossing rule over a stored vertex table.
// A load item (mode 0) writes one vertex into the table and gives no result; a
// slot at or above MAX_VERTICES is ignored. A test item (mode 1) walks the
// edges from vertex i to i+1 for i below vertex_count minus one, reading one
// vertex per cycle from the table's single read port; the edges pass the read,
// difference and product stages before the verdict moves into the output
// register (with no walk when vertex_count is below 2, which gives outside),
// later while an earlier result still waits there, and the next item is
// accepted once the verdict has moved. The result waits in an output register,
// so the next item is taken while it is still pending. The closing vertex must
// repeat the first; points on a vertex or a non-horizontal edge count as inside.
// vertex_count sits at APB byte address 0 and saturates at MAX_VERTICES.
// Depends on pip_pkg, pip_ctrl and pip_datapath.
module point_in_polygon_test
    import pip_pkg::*;
#(
    parameter int MAX_VERTICES = DEF_MAX_VERTICES,
    parameter int COORD_WIDTH  = DEF_COORD_WIDTH
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    // input items
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          mode,
    input  logic [INDEX_WIDTH-1:0]        vertex_index,
    input  logic signed [COORD_WIDTH-1:0] coord_x,
    input  logic signed [COORD_WIDTH-1:0] coord_y,
    // result items
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          inside_res,
    // configuration port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [PADDR_WIDTH-1:0]        paddr,
    input  logic [PDATA_WIDTH-1:0]        pwdata,
    output logic [PDATA_WIDTH-1:0]        prdata,
    output logic                          pready
);

    localparam int ADDR_WIDTH = $clog2(MAX_VERTICES);

    cmd_t                   cmd;
    status_t                status;
    logic [ADDR_WIDTH-1:0]  wr_addr;
    logic [ADDR_WIDTH-1:0]  rd_addr;
    logic [COUNT_WIDTH-1:0] vertex_count_reg;
    logic                   reg_sel;

    // configuration register
    assign pready  = 1'b1;
    assign reg_sel = (paddr[2] == REG_VERTEX_COUNT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vertex_count_reg <= '0;
        end
        else if (psel && penable && pwrite && pready && reg_sel)
        begin
            vertex_count_reg <= pwdata[COUNT_WIDTH-1:0];
        end
    end

    assign prdata = reg_sel ? PDATA_WIDTH'(vertex_count_reg) : '0;

    // controller
    pip_ctrl #(
        .MAX_VERTICES (MAX_VERTICES)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .mode         (mode),
        .vertex_index (vertex_index),
        .vertex_count (vertex_count_reg),
        .status       (status),
        .cmd          (cmd),
        .wr_addr      (wr_addr),
        .rd_addr      (rd_addr)
    );

    // datapath
    pip_datapath #(
        .MAX_VERTICES (MAX_VERTICES),
        .COORD_WIDTH  (COORD_WIDTH)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .wr_addr    (wr_addr),
        .rd_addr    (rd_addr),
        .coord_x    (coord_x),
        .coord_y    (coord_y),
        .out_ready  (out_ready),
        .status     (status),
        .out_valid  (out_valid),
        .inside_res (inside_res)
    );

endmodule
